// ===== design/dss_pkg.sv =====
// Shared types and constants for the dual stack shared memory block.
package dss_pkg;

	localparam int unsigned DSS_DEPTH = 128;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned OP_W      = 2;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned DEPTH_W   = 8;

	localparam logic signed [WORD_W-1:0] MOST_NEG = {1'b1, {(WORD_W-1){1'b0}}};

	// operation codes; code 3 is a no-op
	typedef enum logic [OP_W-1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_PEEK = 2'd2
	} op_e_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK       = 2'd0,
		STS_OVERFLOW = 2'd1,
		STS_EMPTY    = 2'd2
	} status_e_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_RESP = 1'b1
	} state_e_t;

endpackage

// ===== design/dss_if.sv =====
// Request and response channel interfaces.
interface dss_req_if;
	logic                          valid;
	logic                          ready;
	logic [dss_pkg::OP_W-1:0]      op;
	logic                          stack_select;
	logic signed [dss_pkg::WORD_W-1:0] push_value;

	modport source (output valid, output op, output stack_select, output push_value,
		input ready);
	modport sink (input valid, input op, input stack_select, input push_value,
		output ready);
endinterface

interface dss_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [dss_pkg::WORD_W-1:0] read_value;
	logic [dss_pkg::STATUS_W-1:0]      status;
	logic [dss_pkg::DEPTH_W-1:0]       low_depth;
	logic [dss_pkg::DEPTH_W-1:0]       high_depth;
	logic                              full_flag;

	modport source (output valid, output read_value, output status, output low_depth,
		output high_depth, output full_flag, input ready);
	modport sink (input valid, input read_value, input status, input low_depth,
		input high_depth, input full_flag, output ready);
endinterface

// ===== design/dual_stack_shared_memory.sv =====
// Two stacks sharing one memory of DEPTH words: low stack grows up from
// entry 0, high stack grows down from entry DEPTH-1. In the cycle a
// request is accepted the single RAM port is read or written and the stack
// pointer updated; the next cycle the response is presented, with popped or
// peeked values from the RAM read register, and held until taken. A new
// request is accepted in the cycle after the response is taken. No
// clearing pass after reset; memory entries are only read after a push
// wrote them.
module dual_stack_shared_memory #(
	parameter int unsigned DEPTH = dss_pkg::DSS_DEPTH
) (
	input logic       clk,
	input logic       arst_n,
	dss_req_if.sink   req,
	dss_rsp_if.source rsp
);
	import dss_pkg::*;

	logic take;

	dss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.rsp_ready (rsp.ready),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.take      (take)
	);

	dss_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.op           (req.op),
		.stack_select (req.stack_select),
		.push_value   (req.push_value),
		.read_value   (rsp.read_value),
		.status       (rsp.status),
		.low_depth    (rsp.low_depth),
		.high_depth   (rsp.high_depth),
		.full_flag    (rsp.full_flag)
	);

	// no new request while a response is pending
	a_no_req_while_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready)
		else $error("request accepted while response pending");

	// every accepted request yields a response next cycle
	a_rsp_follows_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> rsp.valid)
		else $error("response missing after request");

	// overflow only reported when memory is full
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == STS_OVERFLOW) |-> rsp.full_flag)
		else $error("overflow without full memory");

	// a pushed request never reports empty
	a_push_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.op == OP_PUSH) |=> rsp.status != STS_EMPTY)
		else $error("push reported empty status");

endmodule

// ===== design/dss_ram.sv =====
// Generic single-port RAM with registered read.
module dss_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/dss_ctrl.sv =====
// Controller: sequences one request through access and response.
module dss_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic rsp_ready,
	output logic req_ready,
	output logic rsp_valid,
	output logic take
);
	import dss_pkg::*;

	state_e_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake outputs
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		take      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					take    = 1'b1;
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				rsp_valid = 1'b1;
				if (rsp_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== design/dss_dp.sv =====
// Datapath: stack pointers, shared memory access and result formation.
module dss_dp #(
	parameter int unsigned DEPTH = dss_pkg::DSS_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              take,
	input  logic [dss_pkg::OP_W-1:0]          op,
	input  logic                              stack_select,
	input  logic signed [dss_pkg::WORD_W-1:0] push_value,
	output logic signed [dss_pkg::WORD_W-1:0] read_value,
	output logic [dss_pkg::STATUS_W-1:0]      status,
	output logic [dss_pkg::DEPTH_W-1:0]       low_depth,
	output logic [dss_pkg::DEPTH_W-1:0]       high_depth,
	output logic                              full_flag
);
	import dss_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned AW = $clog2(DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic [CW-1:0]     low_q, high_q, low_d, high_d, sel_cnt;
	logic [CW:0]       used;
	logic              full;
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_addr;
	logic [WORD_W-1:0] ram_rdata;
	status_e_t         sts_d, sts_q;
	logic              from_ram_d, from_ram_q;

	// occupancy
	assign used    = {1'b0, low_q} + {1'b0, high_q};
	assign full    = (used >= {1'b0, DEPTH_C});
	assign sel_cnt = stack_select ? high_q : low_q;

	// operation decode: memory access, next pointers, status
	always_comb begin
		low_d      = low_q;
		high_d     = high_q;
		sts_d      = STS_OK;
		from_ram_d = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_addr   = '0;
		unique case (op_e_t'(op)) inside
			OP_PUSH: begin
				if (full) begin
					sts_d = STS_OVERFLOW;
				end else if (stack_select) begin
					ram_we   = take;
					ram_addr = AW'(DEPTH_C - CW'(1) - high_q);
					high_d   = high_q + CW'(1);
				end else begin
					ram_we   = take;
					ram_addr = AW'(low_q);
					low_d    = low_q + CW'(1);
				end
			end
			OP_POP, OP_PEEK: begin
				if (sel_cnt == '0) begin
					sts_d = STS_EMPTY;
				end else begin
					ram_re     = take;
					from_ram_d = 1'b1;
					ram_addr   = stack_select ? AW'(DEPTH_C - sel_cnt)
						: AW'(sel_cnt - CW'(1));
					if (op_e_t'(op) == OP_POP) begin
						if (stack_select) begin
							high_d = high_q - CW'(1);
						end else begin
							low_d = low_q - CW'(1);
						end
					end
				end
			end
			default: ;
		endcase
	end

	// pointer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '0;
		end else if (take) begin
			low_q  <= low_d;
			high_q <= high_d;
		end
	end

	// result bookkeeping, held until the next request
	always_ff @(posedge clk) begin
		if (take) begin
			sts_q      <= sts_d;
			from_ram_q <= from_ram_d;
		end
	end

	dss_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (push_value),
		.rdata (ram_rdata)
	);

	// result fields
	assign read_value = from_ram_q ? signed'(ram_rdata)
		: ((sts_q == STS_EMPTY) ? MOST_NEG : '0);
	assign status     = sts_q;
	assign low_depth  = DEPTH_W'(low_q);
	assign high_depth = DEPTH_W'(high_q);
	assign full_flag  = full;

endmodule
